>>> rtl/core/pal555_pkg.sv
// Shared types, codes and the 5-to-8 bit channel expansion table.
package pal555_pkg;

  // Item kind carried on the input tuser.
  typedef enum logic [1:0] {
    ACT_WRITE   = 2'd0,
    ACT_INDEXED = 2'd1,
    ACT_DIRECT  = 2'd2
  } action_t;

  localparam int unsigned COLOR_W  = 16;
  localparam int unsigned INDEX_W  = 8;
  localparam int unsigned COUNT_W  = 9;
  localparam int unsigned ARGB_W   = 32;

  // Alpha bit of a 1-5-5-5 color word.
  localparam logic [COLOR_W-1:0] ALPHA_MASK = 16'h8000;

  // Configuration register byte addresses (bit 2 selects the register).
  localparam logic [2:0] ADDR_COLOR_COUNT = 3'd0;
  localparam logic [2:0] ADDR_KEEP_TRANSP = 3'd4;

  // Palette port request issued on each accepted input transfer.
  typedef struct packed {
    logic               wr_en;
    logic               rd_en;
    logic [INDEX_W-1:0] wr_index;
    logic [COLOR_W-1:0] wr_color;
    logic [INDEX_W-1:0] rd_index;
  } pal_req_t;

  // floor(v * 255 / 31) for v = 0..31.
  localparam logic [7:0] EXPAND5_LUT [32] = '{
    8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
    8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
    8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
    8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
  };

endpackage

>>> rtl/core/palette_rgb555_to_argb8888_top.sv
// Top level of the palette / direct 1-5-5-5 to ARGB8888 pixel converter.
//
// Takes one input transfer per clock unless stalled. Each pixel passes through
// two registers. The edge that accepts the pixel loads the palette store's
// registered read port, with the index clamped to color_count - 1 (the count
// held to 1..PALETTE_DEPTH). The output register takes the expanded channels
// once it is empty or its word is taken. A palette write or an unused kind
// code takes one transfer and gives no output. Throughput is one item per
// clock as long as the output side takes its transfers. s_axis_tready drops
// only while the palette read stage and the output register are both full
// and m_axis_tready is low. A palette entry must be written before a pixel
// reads it, because the store has no reset. The configuration port is APB
// style with pready tied high: address 0 holds color_count (9 bits), address
// 4 holds keep_transparency (1 bit). Write configuration only while no pixel
// is in flight.
module palette_rgb555_to_argb8888_top
  import pal555_pkg::*;
#(
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] entry_index, [23:8] entry_color, [31:24] pixel_index,
  // [47:32] pixel_color
  input  logic [47:0] s_axis_tdata,
  // [1:0] action
  input  logic [1:0]  s_axis_tuser,
  // Output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] argb_word
  output logic [31:0] m_axis_tdata,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration registers
  logic [COUNT_W-1:0] color_count;
  logic               keep_transparency;

  // Unpacked input fields
  action_t            action;
  logic [INDEX_W-1:0] entry_index;
  logic [COLOR_W-1:0] entry_color;
  logic [INDEX_W-1:0] pixel_index;
  logic [COLOR_W-1:0] pixel_color;

  // Read stage: one pixel waiting on the palette read register
  logic               s1_valid;
  logic               s1_direct;
  logic [COLOR_W-1:0] s1_color;

  logic               accept;
  logic               advance;
  logic               is_pixel;
  pal_req_t           req;
  logic [COLOR_W-1:0] palette_color;
  logic [ARGB_W-1:0]  argb_word;

  assign action      = action_t'(s_axis_tuser);
  assign entry_index = s_axis_tdata[7:0];
  assign entry_color = s_axis_tdata[23:8];
  assign pixel_index = s_axis_tdata[31:24];
  assign pixel_color = s_axis_tdata[47:32];

  // --------------------------------------------------------------------
  // Configuration: write on the access cycle, decode on address bit 2
  // --------------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      color_count       <= COUNT_W'(256);
      keep_transparency <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == ADDR_KEEP_TRANSP[2]) begin
        keep_transparency <= pwdata[0];
      end else begin
        color_count <= pwdata[COUNT_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == ADDR_KEEP_TRANSP[2]) begin
      prdata = {31'b0, keep_transparency};
    end else begin
      prdata = {23'b0, color_count};
    end
  end

  // --------------------------------------------------------------------
  // Flow control: the output register advances when empty or taken, the
  // read stage advances with it, and a new transfer is taken whenever the
  // read stage is empty or advancing.
  // --------------------------------------------------------------------
  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !s1_valid || advance;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    case (action)
      ACT_INDEXED: is_pixel = 1'b1;
      ACT_DIRECT:  is_pixel = 1'b1;
      ACT_WRITE:   is_pixel = 1'b0;
      default:     is_pixel = 1'b0;  // unused code: drop the item
    endcase
  end

  always_comb begin
    req          = '0;
    req.wr_en    = accept && (action == ACT_WRITE);
    req.rd_en    = accept && (action == ACT_INDEXED);
    req.wr_index = entry_index;
    req.wr_color = entry_color;
    req.rd_index = pixel_index;
  end

  pal555_palette #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_palette (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .color_count(color_count),
    .rd_color   (palette_color)
  );

  // Hold the pixel kind and direct color alongside the palette read.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= accept && is_pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_direct <= (action == ACT_DIRECT);
      s1_color  <= pixel_color;
    end
  end

  pal555_expand u_expand (
    .direct           (s1_direct),
    .direct_color     (s1_color),
    .palette_color    (palette_color),
    .keep_transparency(keep_transparency),
    .argb_word        (argb_word)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      m_axis_tdata <= argb_word;
    end
  end

endmodule

>>> rtl/core/pal555_palette.sv
// Palette store: index clamp, one write port and one registered read port.
module pal555_palette
  import pal555_pkg::*;
#(
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  pal_req_t           req,
  input  logic [COUNT_W-1:0] color_count,
  output logic [COLOR_W-1:0] rd_color
);

  localparam int unsigned IDX_W = $clog2(PALETTE_DEPTH);
  localparam logic [COUNT_W-1:0] DEPTH_C = COUNT_W'(PALETTE_DEPTH);

  logic [COLOR_W-1:0] store [PALETTE_DEPTH];

  logic [COUNT_W-1:0] count_eff;
  logic [COUNT_W-1:0] last_index;
  logic [COUNT_W-1:0] rd_wide;
  logic [COUNT_W-1:0] wr_wide;
  logic               wr_in_range;

  // Clamp the count to 1..depth, then the read index to count-1.
  always_comb begin
    count_eff = color_count;
    if (count_eff == '0) begin
      count_eff = COUNT_W'(1);
    end
    if (count_eff > DEPTH_C) begin
      count_eff = DEPTH_C;
    end
    last_index = count_eff - COUNT_W'(1);
    rd_wide    = {1'b0, req.rd_index};
    if (rd_wide > last_index) begin
      rd_wide = last_index;
    end
    wr_wide     = {1'b0, req.wr_index};
    wr_in_range = wr_wide < DEPTH_C;
  end

  always_ff @(posedge clk) begin
    if (req.wr_en && wr_in_range) begin
      store[wr_wide[IDX_W-1:0]] <= req.wr_color;
    end
  end

  // Read register; rst is unused by the store itself.
  always_ff @(posedge clk) begin
    if (!rst && req.rd_en) begin
      rd_color <= store[rd_wide[IDX_W-1:0]];
    end
  end

endmodule

>>> rtl/core/pal555_expand.sv
// Color select, alpha forcing and 1-5-5-5 to ARGB8888 channel expansion.
module pal555_expand
  import pal555_pkg::*;
(
  input  logic               direct,
  input  logic [COLOR_W-1:0] direct_color,
  input  logic [COLOR_W-1:0] palette_color,
  input  logic               keep_transparency,
  output logic [ARGB_W-1:0]  argb_word
);

  logic [COLOR_W-1:0] color;
  logic [7:0]         alpha;

  always_comb begin
    color = direct ? direct_color : palette_color;
    if (!keep_transparency) begin
      color = color | ALPHA_MASK;
    end
    alpha     = color[15] ? 8'hFF : 8'h00;
    argb_word = {alpha,
                 EXPAND5_LUT[color[14:10]],
                 EXPAND5_LUT[color[9:5]],
                 EXPAND5_LUT[color[4:0]]};
  end

endmodule

>>> rtl/core/pal555_checker.sv
// Port-level checks for the pixel converter, bound to the top level.
module pal555_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  // A stalled output transfer keeps its word.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  // Reset empties the output register.
  assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // The input side never stalls while the output side takes transfers.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled with output ready");

  // Alpha is always fully clear or fully set.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[31:24] == 8'h00) || (m_axis_tdata[31:24] == 8'hFF))
    else $error("alpha byte not expanded from one bit");

endmodule

bind palette_rgb555_to_argb8888_top pal555_checker u_pal555_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

>>> test/tb.sv
// Self-checking testbench for the 1-5-5-5 palette / direct pixel to ARGB8888 converter.
`timescale 1ns / 100ps

module tb;
  import pal555_pkg::*;

  localparam int DEPTH        = 256;
  localparam int CYCLE_LIMIT  = 400000;
  // Settling clocks after the last predicted word came out, with some margin.
  localparam int DRAIN_CYCLES = 8;
  // One long output hold-off, started once this many transfers went in.
  localparam int HOLD_AT      = 900;
  localparam int HOLD_LEN     = 200;
  localparam int PHASES       = 6;
  // Kind code with no meaning; the block drops such transfers.
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic [COLOR_W-1:0] pixel_color;
    logic [INDEX_W-1:0] pixel_index;
    logic [COLOR_W-1:0] entry_color;
    logic [INDEX_W-1:0] entry_index;
  } pix_fields_t;

  typedef struct packed {
    logic [1:0]  action;
    pix_fields_t f;
  } pix_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               keep;
    logic [11:0]        items;
  } phase_plan_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // [7:0] entry_index, [23:8] entry_color, [31:24] pixel_index, [47:32] pixel_color
  logic [47:0] s_axis_tdata = '0;
  // [1:0] action
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [31:0] argb_word
  logic [31:0] m_axis_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Items waiting for the driver, and predicted output words in order.
  pix_item_t   pixel_feed [$];
  logic [31:0] argb_expected [$];

  // Predictor state: palette copy, updated on acceptance, and register copies.
  logic [COLOR_W-1:0] pal_mirror [DEPTH];
  logic [COUNT_W-1:0] cfg_count = 9'd256;
  logic               cfg_keep = 1'b0;

  // Generator bookkeeping: which entries the queued items will have written.
  logic [DEPTH-1:0]   gen_written = '0;
  logic [COUNT_W-1:0] gen_count = 9'd256;

  pix_item_t   offered;
  logic [31:0] argb_want;
  int unsigned in_count = 0;
  int unsigned n_checked = 0;
  int unsigned n_errors = 0;
  int unsigned cycles = 0;
  int unsigned src_gap = 0;
  int unsigned sink_stall = 0;
  int unsigned hold_cnt = 0;
  bit          hold_used = 1'b0;
  bit          quiet_tail = 1'b0;

  palette_rgb555_to_argb8888_top #(
    .PALETTE_DEPTH(DEPTH)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // Stretch a 5-bit channel to 8 bits: v * 255 / 31, rounded down.
  function automatic logic [7:0] widen5(logic [4:0] v);
    return 8'((32'(v) * 255) / 31);
  endfunction

  // Alpha is the A bit times 255, i.e. all ones or all zeros.
  function automatic logic [31:0] argb_of(logic [COLOR_W-1:0] c);
    return {{8{c[15]}}, widen5(c[14:10]), widen5(c[9:5]), widen5(c[4:0])};
  endfunction

  // Limit an index to count - 1; a count of zero acts as one, counts past
  // the depth act as the depth.
  function automatic logic [INDEX_W-1:0] clamp_index(logic [INDEX_W-1:0] idx,
                                                     logic [COUNT_W-1:0] count);
    int lim;
    lim = count;
    if (lim < 1) lim = 1;
    if (lim > DEPTH) lim = DEPTH;
    return (idx >= lim) ? INDEX_W'(lim - 1) : idx;
  endfunction

  // Apply one accepted transfer: update the palette copy or predict a word.
  function automatic void convert_item(pix_item_t it);
    logic [COLOR_W-1:0] color;
    color = '0;
    case (it.action)
      ACT_WRITE:   pal_mirror[it.f.entry_index] = it.f.entry_color;
      ACT_INDEXED: color = pal_mirror[clamp_index(it.f.pixel_index, cfg_count)];
      ACT_DIRECT:  color = it.f.pixel_color;
      default: ;
    endcase
    if (it.action == ACT_INDEXED || it.action == ACT_DIRECT) begin
      if (!cfg_keep) color |= ALPHA_MASK;
      argb_expected.push_back(argb_of(color));
    end
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    n_errors++;
  endtask

  // ---------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------

  // Fields that belong to other kinds are filled at random; the block must
  // ignore them.
  function automatic pix_item_t any_item(logic [1:0] act);
    pix_item_t   it;
    logic [63:0] r;
    r = {$urandom, $urandom};
    it.f = r[47:0];
    it.action = act;
    return it;
  endfunction

  function automatic void queue_write(logic [INDEX_W-1:0] idx, logic [COLOR_W-1:0] color);
    pix_item_t it;
    it = any_item(ACT_WRITE);
    it.f.entry_index = idx;
    it.f.entry_color = color;
    pixel_feed.push_back(it);
    gen_written[idx] = 1'b1;
  endfunction

  // Never let a pixel read an entry that was not written: fill the entry
  // that the clamped index lands on first if needed.
  function automatic void queue_indexed(logic [INDEX_W-1:0] idx);
    pix_item_t          it;
    logic [INDEX_W-1:0] slot;
    slot = clamp_index(idx, gen_count);
    if (!gen_written[slot]) queue_write(slot, COLOR_W'($urandom));
    it = any_item(ACT_INDEXED);
    it.f.pixel_index = idx;
    pixel_feed.push_back(it);
  endfunction

  function automatic void queue_direct(logic [COLOR_W-1:0] color);
    pix_item_t it;
    it = any_item(ACT_DIRECT);
    it.f.pixel_color = color;
    pixel_feed.push_back(it);
  endfunction

  // Mostly pixels, a steady share of palette updates, a few dropped codes.
  // Half the indexed pixels stay inside the valid range, half roam freely.
  function automatic void queue_random(int unsigned n);
    int unsigned pick;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 20)
        queue_write(INDEX_W'($urandom), COLOR_W'($urandom));
      else if (pick < 60)
        queue_indexed((pick & 1) ? INDEX_W'($urandom)
                      : INDEX_W'($urandom_range(0, clamp_index(8'hFF, gen_count))));
      else if (pick < 95)
        queue_direct(COLOR_W'($urandom));
      else
        pixel_feed.push_back(any_item(ACT_UNUSED));
    end
  endfunction

  // Register setting and number of random items of each phase that follows
  // the directed part.
  function automatic phase_plan_t phase_plan(int p);
    case (p)
      0:       return '{9'd1,   1'b1, 12'd250};
      1:       return '{9'd0,   1'b0, 12'd200};
      2:       return '{9'd37,  1'b1, 12'd350};
      3:       return '{9'd300, 1'b1, 12'd300};
      4:       return '{9'd511, 1'b0, 12'd200};
      default: return '{9'd128, 1'b1, 12'd300};
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Configuration port and phase control
  // ---------------------------------------------------------------------

  // Setup cycle, then access cycle; the register takes the value at the
  // edge that closes the access cycle.
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_COLOR_COUNT) cfg_count = value[COUNT_W-1:0];
    else cfg_keep = value[0];
  endtask

  // Wait until every queued item went in and every predicted word came out,
  // then let the pipeline settle so a trailing write or dropped code is done.
  task automatic wait_idle();
    @(negedge clk);
    while (pixel_feed.size() != 0 || s_axis_tvalid || argb_expected.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Input driver: offer items from the feed, with random gaps
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      src_gap       <= 0;
      in_count      <= 0;
    end else begin
      // Predict from the item that completed a transfer at this edge.
      if (s_axis_tvalid && s_axis_tready) begin
        convert_item(offered);
        in_count <= in_count + 1;
      end
      // Advance only when nothing is held or the held item just went in.
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap != 0) begin
          src_gap       <= src_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pixel_feed.size() != 0) begin
          offered = pixel_feed.pop_front();
          s_axis_tdata  <= offered.f;
          s_axis_tuser  <= offered.action;
          s_axis_tvalid <= 1'b1;
          if (!quiet_tail && $urandom_range(0, 7) == 0) src_gap <= $urandom_range(1, 10);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output hold-off: once, stall the output long enough to back up the
  // input while the driver keeps offering.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      hold_cnt  <= 0;
      hold_used <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (!hold_used && in_count >= HOLD_AT) begin
      hold_cnt  <= HOLD_LEN;
      hold_used <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------
  // Output monitor: check each transfer against the oldest prediction,
  // and drop tready in random bursts.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      sink_stall    <= 0;
      n_checked     <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (argb_expected.size() == 0) begin
          flag_mismatch($sformatf("output %08h with no pixel pending", m_axis_tdata));
        end else begin
          argb_want = argb_expected.pop_front();
          if (m_axis_tdata !== argb_want)
            flag_mismatch($sformatf("pixel %0d argb_word %08h, predicted %08h",
                                    n_checked, m_axis_tdata, argb_want));
          n_checked <= n_checked + 1;
        end
      end
      if (sink_stall != 0) begin
        sink_stall    <= sink_stall - 1;
        m_axis_tready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        sink_stall    <= $urandom_range(0, 9);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= (hold_cnt == 0);
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles, %0d words still pending",
               cycles, argb_expected.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin
    phase_plan_t plan;
    pix_item_t   junk;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part under reset settings (all colors, opaque alpha).
    // Fill the first and last entries and a few channel extremes.
    queue_write(8'h00, 16'h0000);
    queue_write(8'hFF, 16'hFFFF);
    queue_write(8'h01, 16'h7FFF);
    queue_write(8'h02, 16'h8000);
    queue_write(8'h03, 16'h7C00);
    queue_indexed(8'h00);
    queue_indexed(8'hFF);
    queue_indexed(8'h01);
    queue_indexed(8'h02);
    queue_indexed(8'h03);
    // Direct pixels: black, white, each channel alone, alpha alone.
    queue_direct(16'h0000);
    queue_direct(16'hFFFF);
    queue_direct(16'h7C00);
    queue_direct(16'h03E0);
    queue_direct(16'h001F);
    queue_direct(16'h8000);
    queue_direct(16'h7FFF);
    // Unused kind code: once with every field bit set, once random.
    junk = any_item(ACT_UNUSED);
    junk.f = '1;
    pixel_feed.push_back(junk);
    pixel_feed.push_back(any_item(ACT_UNUSED));
    queue_random(250);

    // Walk through register settings, including count zero, one and
    // values past the depth, with both alpha modes.
    for (int p = 0; p < PHASES; p++) begin
      plan = phase_plan(p);
      wait_idle();
      write_reg(ADDR_COLOR_COUNT, 32'(plan.count));
      write_reg(ADDR_KEEP_TRANSP, 32'(plan.keep));
      gen_count = plan.count;
      @(negedge clk);
      // Last phase runs without gaps or stalls on either side.
      if (p == PHASES - 1) quiet_tail = 1'b1;
      // Clamp edges and alpha handling under the new setting.
      queue_indexed(8'hFF);
      queue_indexed(8'h00);
      queue_direct(16'h7FFF);
      queue_direct(16'h8000);
      queue_random(plan.items);
    end
    wait_idle();

    $display("Run: %0d input transfers, %0d output words checked over %0d register settings",
             in_count, n_checked, PHASES + 1);
    $display("Color counts 0, 1, 37, 128, 256, 300 and 511, both alpha modes, one %0d-cycle hold-off",
             HOLD_LEN);
    if (n_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
